### hdl/rbbt_pkg.sv
// ----------------------------------------------------------------------------
// rbbt_pkg
// Shared types and constants of the ray break breach tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rbbt_pkg;

  localparam int LenW       = 32;   // ray and flame length, Q16.16
  localparam int CfgDataW   = 32;
  localparam int CfgIdxW    = 2;
  localparam int StopW      = 32;   // stop point coordinates
  localparam int RayEndW    = 40;   // ray end, Q24.16
  localparam int DigitW     = 16;   // multiplier digit per cycle
  localparam int ProdW      = 2 * LenW;
  localparam int LimitShift = 17;
  localparam int LimitW     = ProdW - LimitShift + 2;

  localparam logic [CfgDataW-1:0] GpmReset = 32'h0001_0000;
  localparam logic [CfgDataW-1:0] AdvReset = 32'h0001_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_SCALE      = 2'd0,
    REG_BREACH_ADVANCE  = 2'd1,
    REG_ALLOW_BREACHING = 2'd2
  } rbbt_reg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_MUL,
    OP_ROOT,
    OP_MERGE,
    OP_DECIDE,
    OP_EMIT
  } rbbt_op_t;

  typedef struct packed {
    logic ray_done;
    logic mul_last;
    logic root_last;
  } rbbt_status_t;

endpackage

`default_nettype wire

### hdl/rbbt_if.sv
// ----------------------------------------------------------------------------
// rbbt_if
// Segment, result and configuration channels of the breach tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbbt_seg_if #(
  parameter int COORD_WIDTH = 32
);
  import rbbt_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          first_segment;
  logic        [LenW-1:0]        ray_length;
  logic        [LenW-1:0]        flame_length;
  logic signed [COORD_WIDTH-1:0] entry_x;
  logic signed [COORD_WIDTH-1:0] entry_y;
  logic signed [COORD_WIDTH-1:0] exit_x;
  logic signed [COORD_WIDTH-1:0] exit_y;
  logic                          outside_plot;
  logic                          non_fuel;

  modport source (
    output valid, first_segment, ray_length, flame_length,
           entry_x, entry_y, exit_x, exit_y, outside_plot, non_fuel,
    input  ready
  );
  modport sink (
    input  valid, first_segment, ray_length, flame_length,
           entry_x, entry_y, exit_x, exit_y, outside_plot, non_fuel,
    output ready
  );
endinterface

interface rbbt_res_if;
  import rbbt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    keep_going;
  logic                    stopped_by_nonfuel;
  logic signed [StopW-1:0] stop_x;
  logic signed [StopW-1:0] stop_y;
  logic      [RayEndW-1:0] ray_end;
  logic                    breached;

  modport source (
    output valid, keep_going, stopped_by_nonfuel, stop_x, stop_y, ray_end, breached,
    input  ready
  );
  modport sink (
    input  valid, keep_going, stopped_by_nonfuel, stop_x, stop_y, ray_end, breached,
    output ready
  );
endinterface

interface rbbt_cfg_if;
  import rbbt_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/rbbt_ctrl.sv
// ----------------------------------------------------------------------------
// rbbt_ctrl
// Sequencer: accept, setup, digit multiply, bit-serial root, merge, decide,
// hand the result word to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbbt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rbbt_pkg::rbbt_status_t status,
  output rbbt_pkg::rbbt_op_t     op
);
  import rbbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_ROOT,
    S_MERGE,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state;
  logic   emit_go;

  assign in_ready = (state == S_IDLE);
  // the result register may be reloaded in the cycle it is taken
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    unique case (state)
      S_IDLE:   op = in_valid ? OP_LOAD : OP_NONE;
      S_CHECK:  op = OP_CHECK;
      S_MUL:    op = OP_MUL;
      S_ROOT:   op = OP_ROOT;
      S_MERGE:  op = OP_MERGE;
      S_DECIDE: op = OP_DECIDE;
      S_EMIT:   op = emit_go ? OP_EMIT : OP_NONE;
      default:  op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          // finished ray: the word is repeated without any arithmetic
          state <= status.ray_done ? S_EMIT : S_MUL;
        end
        S_MUL: begin
          if (status.mul_last) state <= S_ROOT;
        end
        S_ROOT: begin
          if (status.root_last) state <= S_MERGE;
        end
        S_MERGE:  state <= S_DECIDE;
        S_DECIDE: state <= S_EMIT;
        S_EMIT: begin
          if (emit_go) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase

      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted word did not start setup");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && !out_ready) |=> (state == S_EMIT && out_valid))
    else $error("pending result overwritten");

  a_mul_to_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && status.mul_last) |=> (state == S_ROOT))
    else $error("multiply did not hand over to root");

  a_root_to_merge: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && status.root_last) |=> (state == S_MERGE))
    else $error("root did not finish into merge");
`endif

endmodule

`default_nettype wire

### hdl/rbbt_dp.sv
// ----------------------------------------------------------------------------
// rbbt_dp
// Datapath: ray state, digit-serial squares, bit-per-cycle root, break limit
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbbt_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int ACC_WIDTH   = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rbbt_pkg::rbbt_op_t                  op,
  output rbbt_pkg::rbbt_status_t              status,
  input  logic                                cfg_we,
  input  logic [rbbt_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [rbbt_pkg::CfgDataW-1:0]       cfg_data,
  input  logic                                first_segment,
  input  logic [rbbt_pkg::LenW-1:0]           ray_length,
  input  logic [rbbt_pkg::LenW-1:0]           flame_length,
  input  logic signed [COORD_WIDTH-1:0]       entry_x,
  input  logic signed [COORD_WIDTH-1:0]       entry_y,
  input  logic signed [COORD_WIDTH-1:0]       exit_x,
  input  logic signed [COORD_WIDTH-1:0]       exit_y,
  input  logic                                outside_plot,
  input  logic                                non_fuel,
  output logic                                keep_going,
  output logic                                stopped_by_nonfuel,
  output logic signed [rbbt_pkg::StopW-1:0]   stop_x,
  output logic signed [rbbt_pkg::StopW-1:0]   stop_y,
  output logic [rbbt_pkg::RayEndW-1:0]        ray_end,
  output logic                                breached
);
  import rbbt_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int AW     = ACC_WIDTH;
  localparam int R      = CW + 1;                    // root bits
  localparam int SW     = 2 * R;                     // sum of squares
  localparam int ND     = (CW + DigitW - 1) / DigitW;
  localparam int KW     = (ND > 1) ? $clog2(ND) : 1;
  localparam int NSTEPS = (2 * ND > R) ? 2 * ND : R;
  localparam int CNTW   = $clog2(NSTEPS);
  localparam int RMW    = R + 2;
  localparam int PW     = CW + DigitW;
  localparam int SA     = ((AW > R) ? AW : R) + 1;
  localparam int CMPW   = (AW > LimitW) ? AW : LimitW;
  localparam int XW     = (CW > StopW) ? CW : StopW;
  localparam int EW     = (AW > RayEndW) ? AW : RayEndW;
  localparam logic [AW-1:0]      AccMax = '1;
  localparam logic [RayEndW-1:0] EndMax = '1;

  function automatic logic [AW-1:0] sat_add(logic [AW-1:0] a, logic [SA-2:0] b);
    logic [SA-1:0] s;
    s = SA'(a) + SA'(b);
    return (s > SA'(AccMax)) ? AccMax : s[AW-1:0];
  endfunction

  // configuration
  logic [CfgDataW-1:0] gpm;
  logic [CfgDataW-1:0] adv;
  logic                allow;

  // ray state
  logic [AW-1:0]          trav;
  logic [AW-1:0]          bt;
  logic signed [CW-1:0]   bex;
  logic signed [CW-1:0]   bey;
  logic [LenW-1:0]        ray_limit;
  logic [LenW-1:0]        ray_flame;
  logic [AW-1:0]          end_length;
  logic                   ray_done;
  logic                   stop_flag;

  // per-segment work registers
  logic signed [CW-1:0]   ent_x;
  logic signed [CW-1:0]   ent_y;
  logic signed [CW:0]     dfx;
  logic signed [CW:0]     dfy;
  logic [CW-1:0]          mx;
  logic [CW-1:0]          my;
  logic                   nf_out;
  logic                   nf_any;
  logic                   keep;
  logic                   merged;
  logic [CNTW-1:0]        cnt;
  logic [SW-1:0]          sum;
  logic [RMW-1:0]         rem;
  logic [R-1:0]           root;
  logic [ProdW-1:0]       prod;
  logic [LimitW-1:0]      lim;

  // multiply step
  logic                   mul_sel;
  logic [KW-1:0]          k;
  logic [CW-1:0]          opnd;
  logic [ND*DigitW-1:0]   opnd_pad;
  logic [DigitW-1:0]      digit;
  logic [PW-1:0]          partial;
  logic [SW-1:0]          addend;

  // root step
  logic [1:0]             pair;
  logic [RMW-1:0]         remsh;
  logic [RMW-1:0]         trial;
  logic                   fits;

  // decision terms
  logic                   zero;
  logic                   may;
  logic                   do_break;
  logic                   do_merge;
  logic [AW-1:0]          bt_sum;
  logic [AW-1:0]          tr_sum;
  logic                   bt_over;
  logic                   tr_over;
  logic [AW-1:0]          tr_dist;
  logic                   tr_dist_over;
  logic [AW-1:0]          end_adv;
  logic [LimitW-1:0]      lim_calc;
  logic [ProdW-LimitShift-1:0] ph;
  logic [LimitShift-1:0]  pl;
  logic [LimitShift+1:0]  pl3;
  logic [XW-1:0]          sx_ext;
  logic [XW-1:0]          sy_ext;
  logic [EW-1:0]          end_ext;

  assign mul_sel  = (cnt >= CNTW'(ND));
  assign k        = mul_sel ? KW'(cnt - CNTW'(ND)) : KW'(cnt);
  assign opnd     = mul_sel ? my : mx;
  assign opnd_pad = (ND*DigitW)'(opnd);
  assign digit    = opnd_pad[k*DigitW +: DigitW];
  assign partial  = PW'(opnd) * PW'(digit);
  assign addend   = SW'(partial) << (DigitW * int'(k));

  assign pair  = sum[SW-1 -: 2];
  assign remsh = {rem[RMW-3:0], pair};
  assign trial = {root, 2'b01};
  assign fits  = (remsh >= trial);

  assign status.ray_done  = ray_done;
  assign status.mul_last  = (cnt == CNTW'(2*ND - 1));
  assign status.root_last = (cnt == CNTW'(R - 1));

  assign zero     = (root == '0);
  assign may      = allow && !nf_out;
  assign do_break = !zero && nf_any && may;
  assign do_merge = !zero && !nf_any && (bt != '0);

  assign bt_sum       = sat_add(bt, (SA-1)'(root));
  assign tr_sum       = sat_add(trav, (SA-1)'(bt));
  assign bt_over      = CMPW'(bt) > CMPW'(lim);
  assign tr_over      = trav > AW'(ray_limit);
  assign tr_dist      = sat_add(trav, (SA-1)'(root));
  assign tr_dist_over = tr_dist > AW'(ray_limit);
  assign end_adv      = sat_add(trav, (SA-1)'(adv));

  // 3 * flame * gpm / 2^17, split so the fraction carries exactly
  assign ph       = prod[ProdW-1:LimitShift];
  assign pl       = prod[LimitShift-1:0];
  assign pl3      = {2'b00, pl} + {1'b0, pl, 1'b0};
  assign lim_calc = {2'b00, ph} + {1'b0, ph, 1'b0} + LimitW'(pl3[LimitShift+1:LimitShift]);

  assign sx_ext  = XW'(bex);
  assign sy_ext  = XW'(bey);
  assign end_ext = EW'(end_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      gpm        <= GpmReset;
      adv        <= AdvReset;
      allow      <= 1'b0;
      trav       <= '0;
      bt         <= '0;
      bex        <= '0;
      bey        <= '0;
      ray_limit  <= '0;
      ray_flame  <= '0;
      end_length <= '0;
      ray_done   <= 1'b1;
      stop_flag  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_SCALE:      gpm   <= cfg_data;
          REG_BREACH_ADVANCE:  adv   <= cfg_data;
          REG_ALLOW_BREACHING: allow <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (op)
        OP_LOAD: begin
          if (first_segment) begin
            trav       <= '0;
            bt         <= '0;
            bex        <= '0;
            bey        <= '0;
            ray_limit  <= ray_length;
            ray_flame  <= flame_length;
            end_length <= AW'(ray_length);
            ray_done   <= 1'b0;
            stop_flag  <= 1'b0;
          end
        end
        OP_MERGE: begin
          if (do_break) begin
            if (bt == '0) begin
              bex <= ent_x;
              bey <= ent_y;
            end
            bt <= bt_sum;
          end else if (do_merge) begin
            trav <= tr_sum;
            bt   <= '0;
          end
        end
        OP_DECIDE: begin
          if (!zero) begin
            if (nf_any && !may) begin
              bex       <= ent_x;
              bey       <= ent_y;
              stop_flag <= 1'b1;
              ray_done  <= 1'b1;
            end else if (nf_any) begin
              if (bt_over) begin
                stop_flag <= 1'b1;
                ray_done  <= 1'b1;
              end
            end else if (merged && tr_over) begin
              end_length <= end_adv;
              ray_done   <= 1'b1;
            end else begin
              trav <= tr_dist;
              if (tr_dist_over) ray_done <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        ent_x  <= entry_x;
        ent_y  <= entry_y;
        dfx    <= (CW+1)'(exit_x) - (CW+1)'(entry_x);
        dfy    <= (CW+1)'(exit_y) - (CW+1)'(entry_y);
        nf_out <= outside_plot;
        nf_any <= outside_plot | non_fuel;
        keep   <= 1'b0;
      end
      OP_CHECK: begin
        mx   <= dfx[CW] ? CW'(-dfx) : CW'(dfx);
        my   <= dfy[CW] ? CW'(-dfy) : CW'(dfy);
        cnt  <= '0;
        sum  <= '0;
        rem  <= '0;
        root <= '0;
        prod <= ProdW'(ray_flame) * ProdW'(gpm);
      end
      OP_MUL: begin
        sum <= sum + addend;
        lim <= lim_calc;
        cnt <= status.mul_last ? '0 : cnt + 1'b1;
      end
      OP_ROOT: begin
        sum <= sum << 2;
        cnt <= cnt + 1'b1;
        if (fits) begin
          rem  <= remsh - trial;
          root <= {root[R-2:0], 1'b1};
        end else begin
          rem  <= remsh;
          root <= {root[R-2:0], 1'b0};
        end
      end
      OP_MERGE: begin
        merged <= do_merge;
      end
      OP_DECIDE: begin
        if (zero) begin
          keep <= 1'b1;
        end else if (nf_any) begin
          keep <= may && !bt_over;
        end else begin
          keep <= !(merged && tr_over) && !tr_dist_over;
        end
      end
      OP_EMIT: begin
        keep_going         <= keep;
        stopped_by_nonfuel <= stop_flag;
        stop_x             <= stop_flag ? sx_ext[StopW-1:0] : '0;
        stop_y             <= stop_flag ? sy_ext[StopW-1:0] : '0;
        ray_end            <= (end_ext > EW'(EndMax)) ? EndMax : end_ext[RayEndW-1:0];
        breached           <= !stop_flag && (end_length != AW'(ray_limit));
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hdl/ray_break_breach_tracker_core.sv
// ----------------------------------------------------------------------------
// ray_break_breach_tracker_core
// Tracks one ray over its grid-cell segments: travelled distance, non-fuel
// stops and breaches of narrow breaks, one result word per segment.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | contents
//  seg     | in  | valid/ready | segment end points, flags, ray and flame length
//  res     | out | valid/ready | keep_going, stop flag and point, ray end, breached
//  cfg     | in  | valid/ready | register index and write data, always ready
//
//  a segment goes from accept through setup, the digit-serial squares, the
//  bit-per-cycle square root of dx*dx+dy*dy, merge and decide to its result;
//  a segment after the ray finished goes from setup straight to its result.
//  one segment is in work at a time; the next is taken while the result
//  word waits. rst is synchronous and restores register defaults, no ray active.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_break_breach_tracker_core #(
  parameter int COORD_WIDTH = 32,
  parameter int ACC_WIDTH   = 40
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rbbt_seg_if.sink    seg,
  rbbt_res_if.source  res,
  rbbt_cfg_if.sink    cfg
);
  import rbbt_pkg::*;

  rbbt_op_t     op;
  rbbt_status_t status;
  logic         cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  rbbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg.valid),
    .in_ready  (seg.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .op        (op)
  );

  rbbt_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .op                 (op),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg.index),
    .cfg_data           (cfg.data),
    .first_segment      (seg.first_segment),
    .ray_length         (seg.ray_length),
    .flame_length       (seg.flame_length),
    .entry_x            (seg.entry_x),
    .entry_y            (seg.entry_y),
    .exit_x             (seg.exit_x),
    .exit_y             (seg.exit_y),
    .outside_plot       (seg.outside_plot),
    .non_fuel           (seg.non_fuel),
    .keep_going         (res.keep_going),
    .stopped_by_nonfuel (res.stopped_by_nonfuel),
    .stop_x             (res.stop_x),
    .stop_y             (res.stop_y),
    .ray_end            (res.ray_end),
    .breached           (res.breached)
  );

endmodule

`default_nettype wire
